[design/acsb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsb_pkg
// Shared types and constants of the counting semaphore bank.
// ----------------------------------------------------------------------------
package acsb_pkg;

  localparam int NUM_SEMS = 256;
  localparam int IDX_W    = 8;
  localparam int VAL_W    = 15;
  localparam int REQ_W    = 16;
  localparam int CNT_W    = 9;
  localparam logic [VAL_W:0] SEM_MAX = 16'd32767;

  typedef enum logic [1:0] {
    OP_BATCH   = 2'd0,
    OP_SET     = 2'd1,
    OP_GET_VAL = 2'd2,
    OP_GET_REQ = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_BLOCK  = 3'd1,
    STAT_AGAIN  = 3'd2,
    STAT_BADIDX = 3'd3,
    STAT_RANGE  = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_CM_A,
    ST_CM_B,
    ST_CM_C,
    ST_OUT
  } state_t;

  // Result of one pass through the shared arithmetic unit
  typedef struct packed {
    logic              fail;
    stat_t             st;
    logic [VAL_W-1:0]  val;
  } alu_res_t;

endpackage

[design/acsb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module acsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/acsb_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsb_alu
// Shared add and compare unit for one batch step on a staged or committed value.
// ----------------------------------------------------------------------------
module acsb_alu (
  input  logic [acsb_pkg::VAL_W-1:0] cur,
  input  logic signed [15:0]         amount,
  input  logic                       no_wait,
  output acsb_pkg::alu_res_t         res
);
  import acsb_pkg::*;

  logic signed [16:0] sum;
  stat_t              blk_st;

  assign sum    = $signed({2'b00, cur}) + $signed({amount[15], amount});
  assign blk_st = no_wait ? STAT_AGAIN : STAT_BLOCK;

  // Take, wait-for-zero or give
  always_comb begin
    res.fail = 1'b0;
    res.st   = STAT_OK;
    res.val  = cur;
    if (amount[15]) begin
      if (sum[16]) begin
        res.fail = 1'b1;
        res.st   = blk_st;
      end else begin
        res.val = sum[VAL_W-1:0];
      end
    end else if (amount == 16'sd0) begin
      if (cur != '0) begin
        res.fail = 1'b1;
        res.st   = blk_st;
      end
    end else begin
      if (sum[VAL_W]) begin
        res.fail = 1'b1;
        res.st   = STAT_RANGE;
      end else begin
        res.val = sum[VAL_W-1:0];
      end
    end
  end

endmodule

[design/atomic_counting_semaphore_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_counting_semaphore_bank
// Bank of 256 counting semaphores with atomic batches of operations.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake; tuser carries the opcode, tlast marks
//           the final item of a batch. Batch items without tlast give no
//           result; every other item gives exactly one result item.
//   out_* : status and read data, held in an output register until taken.
//   cfg_* : writes set_size, the number of semaphores in use; always ready.
// Flow: an item passes through the read and execute states, then ST_OUT
//   loads the output register. A batch end also walks the touched list,
//   through CM_A, CM_B and CM_C for each semaphore touched by the batch,
//   limited by the single read port of the staging and touched-list RAMs.
//   in_tready is high only while the sequencer waits for an item.
// Reset: all values and last requesters read as zero, set_size is 1,
//   staging is empty. No clearing pass is needed.
// Stall: a held result blocks only the next result; the next item is
//   still taken and runs up to its own output load.
// ----------------------------------------------------------------------------
module atomic_counting_semaphore_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] sem_index, [23:8] amount, [24] no_wait, [40:25] requester,
  // [56:41] set_value, [63:57] zero
  input  logic [63:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [18:3] read_data, [23:19] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import acsb_pkg::*;

  state_t state_r, state_nxt;

  // Item registers
  opcode_t            op_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [15:0] amt_r;
  logic               nw_r;
  logic               last_r;
  logic [REQ_W-1:0]   req_r;
  logic [15:0]        sv_r;

  logic [CNT_W-1:0]   set_size_r;
  logic [CNT_W-1:0]   tch_cnt_r;
  logic [CNT_W-1:0]   cm_i_r;
  stat_t              bst_r;
  logic [NUM_SEMS-1:0] sem_vld_r;
  logic [NUM_SEMS-1:0] stg_vld_r;

  logic               out_vld_r;
  stat_t              res_st_r;
  logic [15:0]        res_data_r;
  stat_t              pnd_st_r;
  logic [15:0]        pnd_data_r;
  stat_t              res_st_nxt;
  logic [15:0]        res_data_nxt;

  // RAM ports
  logic [VAL_W-1:0] sem_rd, stg_rd, sem_wd, stg_wd;
  logic [REQ_W-1:0] req_rd;
  logic [IDX_W-1:0] tch_rd, sem_wa, stg_ra;
  logic             sem_we, stg_we, tch_we, rd_en, stg_re, tch_re;

  logic        idx_ok, cur_stg, last_walk, out_free, res_load;
  logic [VAL_W-1:0] cur;
  alu_res_t    alu;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_data_r, res_st_r};
  assign out_free   = !out_vld_r || out_tready;

  assign idx_ok    = ({1'b0, idx_r} < set_size_r);
  assign cur_stg   = stg_vld_r[idx_r];
  assign cur       = cur_stg ? stg_rd : (sem_vld_r[idx_r] ? sem_rd : '0);
  assign last_walk = ((cm_i_r + 1'b1) == tch_cnt_r);

  acsb_alu u_alu (
    .cur     (cur),
    .amount  (amt_r),
    .no_wait (nw_r),
    .res     (alu)
  );

  acsb_ram #(.WIDTH(VAL_W), .DEPTH(NUM_SEMS)) u_sem_ram (
    .clk(clk), .wr_en(sem_we), .wr_addr(sem_wa), .wr_data(sem_wd),
    .rd_en(rd_en), .rd_addr(idx_r), .rd_data(sem_rd)
  );

  acsb_ram #(.WIDTH(REQ_W), .DEPTH(NUM_SEMS)) u_req_ram (
    .clk(clk), .wr_en(sem_we), .wr_addr(sem_wa), .wr_data(req_r),
    .rd_en(rd_en), .rd_addr(idx_r), .rd_data(req_rd)
  );

  acsb_ram #(.WIDTH(VAL_W), .DEPTH(NUM_SEMS)) u_stg_ram (
    .clk(clk), .wr_en(stg_we), .wr_addr(idx_r), .wr_data(stg_wd),
    .rd_en(stg_re), .rd_addr(stg_ra), .rd_data(stg_rd)
  );

  acsb_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SEMS)) u_tch_ram (
    .clk(clk), .wr_en(tch_we), .wr_addr(tch_cnt_r[IDX_W-1:0]), .wr_data(idx_r),
    .rd_en(tch_re), .rd_addr(cm_i_r[IDX_W-1:0]), .rd_data(tch_rd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (op_r != OP_BATCH) begin
          state_nxt = ST_OUT;
        end else if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (tch_cnt_r != '0 || tch_we) begin
          state_nxt = ST_CM_A;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CM_A: state_nxt = ST_CM_B;
      ST_CM_B: state_nxt = ST_CM_C;
      ST_CM_C: state_nxt = last_walk ? ST_OUT : ST_CM_A;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    rd_en        = (state_r == ST_RD);
    stg_re       = (state_r == ST_RD) || (state_r == ST_CM_B);
    stg_ra       = (state_r == ST_CM_B) ? tch_rd : idx_r;
    tch_re       = (state_r == ST_CM_A);
    tch_we       = 1'b0;
    stg_we       = 1'b0;
    stg_wd       = alu.val;
    sem_we       = 1'b0;
    sem_wa       = idx_r;
    sem_wd       = sv_r[VAL_W-1:0];
    res_st_nxt   = STAT_OK;
    res_data_nxt = '0;
    res_load     = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        if (op_r == OP_BATCH) begin
          if (bst_r == STAT_OK && idx_ok) begin
            stg_we = 1'b1;
            tch_we = !cur_stg;
          end
        end else if (!idx_ok) begin
          res_st_nxt = STAT_BADIDX;
        end else begin
          unique case (op_r)
            OP_SET: begin
              if (sv_r[15]) begin
                res_st_nxt = STAT_RANGE;
              end else begin
                sem_we = 1'b1;
              end
            end
            OP_GET_VAL: res_data_nxt = sem_vld_r[idx_r] ? {1'b0, sem_rd} : '0;
            OP_GET_REQ: res_data_nxt = sem_vld_r[idx_r] ? req_rd : '0;
            default:    res_data_nxt = '0;
          endcase
        end
        res_load = (op_r != OP_BATCH);
      end
      ST_CM_C: begin
        sem_wa = tch_rd;
        sem_wd = stg_rd;
        sem_we = (bst_r == STAT_OK);
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      set_size_r <= 9'd1;
      tch_cnt_r  <= '0;
      cm_i_r     <= '0;
      bst_r      <= STAT_OK;
      sem_vld_r  <= '0;
      stg_vld_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        set_size_r <= cfg_data;
      end
      // Load a new result or drop the taken one
      if (state_r == ST_OUT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (sem_we) begin
        sem_vld_r[sem_wa] <= 1'b1;
      end
      if (state_r == ST_EXEC && op_r == OP_BATCH && bst_r == STAT_OK) begin
        if (!idx_ok) begin
          bst_r <= STAT_BADIDX;
        end else if (alu.fail) begin
          bst_r <= alu.st;
        end
        if (stg_we) begin
          stg_vld_r[idx_r] <= 1'b1;
        end
        if (tch_we) begin
          tch_cnt_r <= tch_cnt_r + 1'b1;
        end
      end
      if (state_r == ST_EXEC) begin
        cm_i_r <= '0;
      end
      // Walk the touched list, then drop the batch
      if (state_r == ST_CM_C) begin
        stg_vld_r[tch_rd] <= 1'b0;
        cm_i_r <= cm_i_r + 1'b1;
        if (last_walk) begin
          tch_cnt_r <= '0;
        end
      end
      if (state_r == ST_OUT && op_r == OP_BATCH && out_free) begin
        bst_r <= STAT_OK;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      op_r   <= opcode_t'(in_tuser);
      idx_r  <= in_tdata[7:0];
      amt_r  <= in_tdata[23:8];
      nw_r   <= in_tdata[24];
      last_r <= in_tlast;
      req_r  <= in_tdata[40:25];
      sv_r   <= in_tdata[56:41];
    end
    // Hold a single-op result until the output register is free
    if (res_load) begin
      pnd_st_r   <= res_st_nxt;
      pnd_data_r <= res_data_nxt;
    end
    if (state_r == ST_OUT && out_free) begin
      if (op_r == OP_BATCH) begin
        res_st_r   <= bst_r;
        res_data_r <= '0;
      end else begin
        res_st_r   <= pnd_st_r;
        res_data_r <= pnd_data_r;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tch_cnt_r <= CNT_W'(NUM_SEMS))
    else $error("touched count above bank size");

  a_stg_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> $countones(stg_vld_r) == int'(tch_cnt_r))
    else $error("staged entries differ from touched count");

  a_accept_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_RD)
    else $error("accepted item did not start a read");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CM_C && last_walk) |=> (tch_cnt_r == '0 && stg_vld_r == '0))
    else $error("staging not cleared at batch end");
`endif

endmodule
